/* rtl/core/spq_pkg.sv */
// Shared types, field widths, operation and status codes for the sorted priority queue.
// No dependencies; every other file in rtl/core depends on this package.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int PRI_W     = 16;
  localparam int VAL_W     = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
  localparam logic [OP_W-1:0] OP_AT     = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic        [PRI_W-1:0] pri;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
    logic scan_load;
    logic scan_shift;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/spq_if.sv */
// Valid/ready channel interfaces for the request and result items.
// Depends on spq_pkg for field widths; DEPTH sets the position and count widths.
`default_nettype none

interface spq_in_if #(parameter int DEPTH = spq_pkg::DEPTH_DEF);
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::OP_W-1:0]            operation;
  logic [spq_pkg::PRI_W-1:0]           entry_priority;
  logic signed [spq_pkg::VAL_W-1:0]    entry_value;
  logic [$clog2(DEPTH+1)-1:0]          position;

  modport source (output valid, operation, entry_priority, entry_value, position,
                  input ready);
  modport sink   (input valid, operation, entry_priority, entry_value, position,
                  output ready);
endinterface

interface spq_out_if #(parameter int DEPTH = spq_pkg::DEPTH_DEF);
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::ST_W-1:0]            status;
  logic [spq_pkg::PRI_W-1:0]           out_priority;
  logic signed [spq_pkg::VAL_W-1:0]    out_value;
  logic [$clog2(DEPTH+1)-1:0]          out_position;
  logic [$clog2(DEPTH+1)-1:0]          entry_count;

  modport source (output valid, status, out_priority, out_value, out_position, entry_count,
                  input ready);
  modport sink   (input valid, status, out_priority, out_value, out_position, entry_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/spq_cell.sv */
// One queue cell: a stored entry that shifts with its neighbors, plus a scan register.
// Depends on spq_pkg; instantiated DEPTH times by sorted_priority_queue.
`default_nettype none

module spq_cell #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  spq_pkg::cell_cmd_t          cmd,
  input  logic [$clog2(DEPTH+1)-1:0]  count,
  input  logic [$clog2(DEPTH+1)-1:0]  tgt,
  input  spq_pkg::entry_t             new_entry,
  input  spq_pkg::entry_t             left_entry,
  input  logic                        left_ge,
  input  spq_pkg::entry_t             right_entry,
  input  spq_pkg::entry_t             right_scan,
  output spq_pkg::entry_t             entry,
  output logic                        ge,
  output spq_pkg::entry_t             scan
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] IDX = CW'(INDEX);

  assign ge = (IDX < count) && (entry.pri >= new_entry.pri);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!ge) begin
        entry <= left_ge ? new_entry : left_entry;
      end
    end else if (cmd.remove && (IDX >= tgt)) begin
      entry <= right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      scan <= entry;
    end else if (cmd.scan_shift) begin
      scan <= right_scan;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/spq_ctrl.sv */
// Sequencer: decodes each item, drives the cell row, walks the scan line, holds the result.
// Depends on spq_pkg and the spq_in_if / spq_out_if interfaces.
`default_nettype none

module spq_ctrl #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  spq_in_if.sink                      req,
  spq_out_if.source                   rsp,
  input  spq_pkg::entry_t             head,
  output spq_pkg::cell_cmd_t          cmd,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  output logic [$clog2(DEPTH+1)-1:0]  tgt_now,
  output spq_pkg::entry_t             new_entry
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [1:0] M_TAKE   = 2'd0;
  localparam logic [1:0] M_INSERT = 2'd1;
  localparam logic [1:0] M_SEARCH = 2'd2;

  logic [1:0]              state;
  logic [1:0]              mode;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           lim;
  logic [CW-1:0]           tgt;
  logic [PRI_W-1:0]        key_pri;
  logic signed [VAL_W-1:0] key_val;
  logic [ST_W-1:0]         res_status;
  logic [PRI_W-1:0]        res_pri;
  logic signed [VAL_W-1:0] res_val;
  logic [CW-1:0]           res_pos;

  logic                    out_valid;
  logic [ST_W-1:0]         out_status;
  logic [PRI_W-1:0]        out_pri;
  logic signed [VAL_W-1:0] out_val;
  logic [CW-1:0]           out_pos;
  logic [CW-1:0]           out_cnt;

  logic accept;
  logic full;
  logic empty;
  logic pos_bad;
  logic is_take;
  logic ins_ok;
  logic take_ok;
  logic [CW-1:0] k_comb;

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;

  assign full    = (cnt >= FULL_CNT);
  assign empty   = (cnt == '0);
  assign pos_bad = (req.position == '0) || (req.position > cnt);
  assign is_take = (req.operation == OP_HEAD) || (req.operation == OP_TAIL) ||
                   (req.operation == OP_AT);
  assign ins_ok  = (req.operation == OP_INSERT) && !full;
  assign take_ok = is_take && !empty && !((req.operation == OP_AT) && pos_bad);

  always_comb begin
    case (req.operation)
      OP_TAIL: k_comb = cnt - ONE;
      OP_AT:   k_comb = req.position - ONE;
      default: k_comb = '0;
    endcase
  end

  assign cmd.insert     = accept && ins_ok;
  assign cmd.remove     = accept && take_ok;
  assign cmd.scan_load  = accept;
  assign cmd.scan_shift = (state == S_SCAN);
  assign count          = cnt;
  assign tgt_now        = k_comb;
  assign new_entry.pri   = req.entry_priority;
  assign new_entry.value = req.entry_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_pri    <= res_pri;
        out_val    <= res_val;
        out_pos    <= res_pos;
        out_cnt    <= cnt;
        state      <= S_IDLE;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        key_pri    <= req.entry_priority;
        key_val    <= req.entry_value;
        lim        <= cnt;
        tgt        <= k_comb;
        idx        <= '0;
        res_status <= ST_OK;
        res_pri    <= '0;
        res_val    <= '0;
        res_pos    <= '0;
        state      <= S_FIN;
        case (req.operation)
          OP_INSERT: begin
            if (full) begin
              res_status <= ST_FULL;
            end else begin
              mode  <= M_INSERT;
              state <= S_SCAN;
              cnt   <= cnt + ONE;
            end
          end
          OP_HEAD, OP_TAIL, OP_AT: begin
            if (empty) begin
              res_status <= ST_EMPTY;
            end else if (!take_ok) begin
              res_status <= ST_BADPOS;
            end else begin
              mode  <= M_TAKE;
              state <= S_SCAN;
              cnt   <= cnt - ONE;
            end
          end
          OP_SEARCH: begin
            if (empty) begin
              res_status <= ST_EMPTY;
            end else begin
              mode  <= M_SEARCH;
              state <= S_SCAN;
            end
          end
          default: ;
        endcase
      end

      if (state == S_SCAN) begin
        case (mode)
          M_TAKE: begin
            if (idx == tgt) begin
              res_pri <= head.pri;
              res_val <= head.value;
              res_pos <= idx + ONE;
              state   <= S_FIN;
            end else begin
              idx <= idx + ONE;
            end
          end
          M_INSERT: begin
            if (idx == lim || head.pri < key_pri) begin
              res_pos <= idx + ONE;
              state   <= S_FIN;
            end else begin
              idx <= idx + ONE;
            end
          end
          M_SEARCH: begin
            if (idx == lim) begin
              res_status <= ST_NOTFOUND;
              state      <= S_FIN;
            end else if (head.value == key_val) begin
              res_pri <= head.pri;
              res_val <= head.value;
              res_pos <= idx + ONE;
              state   <= S_FIN;
            end else begin
              idx <= idx + ONE;
            end
          end
          default: state <= S_FIN;
        endcase
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_priority = out_pri;
  assign rsp.out_value    = out_val;
  assign rsp.out_position = out_pos;
  assign rsp.entry_count  = out_cnt;

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue: top level, a row of DEPTH cells and the sequencer.
// Depends on spq_pkg, spq_if, spq_cell and spq_ctrl.
//
// Bounded priority queue of DEPTH entries kept in descending priority order, oldest first
// among equal priorities. The store itself changes in the cycle an item is accepted: every
// cell compares its own entry and takes its neighbor's entry or the new one. The result comes
// from a scan line loaded from the cells at the same edge and shifted toward cell 0, one entry
// per cycle, past a single compare at the head. An item rejected outright (full, empty, bad
// position, unused operation) goes straight to the finish state; insert, remove and search
// first shift the scan up to the 0-based slot that they reach. One item is in work at a time;
// the next may be accepted while the previous result waits in the output register.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  spq_in_if.sink     req,
  spq_out_if.source  rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  cell_cmd_t     cmd;
  logic [CW-1:0] count;
  logic [CW-1:0] tgt_now;
  entry_t        new_entry;
  entry_t        ent  [DEPTH];
  entry_t        scan [DEPTH];
  logic          ge   [DEPTH];

  spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head      (scan[0]),
    .cmd       (cmd),
    .count     (count),
    .tgt_now   (tgt_now),
    .new_entry (new_entry)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    entry_t right_e;
    entry_t right_s;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_e = ent[i-1];
      assign left_g = ge[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_e = ent[i];
      assign right_s = scan[i];
    end else begin : g_inner
      assign right_e = ent[i+1];
      assign right_s = scan[i+1];
    end

    spq_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .tgt         (tgt_now),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .right_scan  (right_s),
      .entry       (ent[i]),
      .ge          (ge[i]),
      .scan        (scan[i])
    );
  end

endmodule

`default_nettype wire

/* dv/spq_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the sorted priority queue: keeps a mirror of the queue contents,
// predicts each result when a request item is accepted and compares it when it comes out.
// Depends on spq_pkg and the spq_in_if / spq_out_if channel interfaces.
module spq_result_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  spq_in_if    req,
  spq_out_if   rsp,
  output int   failures,
  output int   pending,
  output int   checked
);
  import spq_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic        [ST_W-1:0]  status;
    logic        [PRI_W-1:0] pri;
    logic signed [VAL_W-1:0] value;
    logic        [PW-1:0]    pos;
    logic        [PW-1:0]    count;
  } outcome_t;

  logic        [PRI_W-1:0] mirror_pri [DEPTH];
  logic signed [VAL_W-1:0] mirror_val [DEPTH];
  int                      mirror_count;
  outcome_t                pending_outcomes [$];

  function automatic outcome_t queue_op_outcome(input logic [OP_W-1:0]         op,
                                                input logic [PRI_W-1:0]        pri,
                                                input logic signed [VAL_W-1:0] val,
                                                input logic [PW-1:0]           pos);
    outcome_t o;
    int       slot;
    int       taken;
    int       i;
    o     = '0;
    taken = -1;
    case (op)
      OP_INSERT: begin
        if (mirror_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < mirror_count && mirror_pri[slot] >= pri) slot++;
          for (i = mirror_count; i > slot; i--) begin
            mirror_pri[i] = mirror_pri[i-1];
            mirror_val[i] = mirror_val[i-1];
          end
          mirror_pri[slot] = pri;
          mirror_val[slot] = val;
          mirror_count++;
          o.pos = PW'(slot + 1);
        end
      end
      OP_HEAD, OP_TAIL, OP_AT, OP_SEARCH: begin
        if (mirror_count == 0) begin
          o.status = ST_EMPTY;
        end else if (op == OP_HEAD) begin
          taken = 0;
        end else if (op == OP_TAIL) begin
          taken = mirror_count - 1;
        end else if (op == OP_AT) begin
          if (pos == 0 || int'(pos) > mirror_count) o.status = ST_BADPOS;
          else taken = int'(pos) - 1;
        end else begin
          o.status = ST_NOTFOUND;
          for (i = 0; i < mirror_count; i++) begin
            if (mirror_val[i] == val) begin
              o.status = ST_OK;
              o.pri    = mirror_pri[i];
              o.value  = mirror_val[i];
              o.pos    = PW'(i + 1);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    if (taken >= 0) begin
      o.pri   = mirror_pri[taken];
      o.value = mirror_val[taken];
      o.pos   = PW'(taken + 1);
      for (i = taken; i + 1 < mirror_count; i++) begin
        mirror_pri[i] = mirror_pri[i+1];
        mirror_val[i] = mirror_val[i+1];
      end
      mirror_count--;
    end
    o.count = PW'(mirror_count);
    return o;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      mirror_count = 0;
      pending_outcomes.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        checked++;
        if (pending_outcomes.size() == 0) begin
          $error("result item with no request awaiting it: status %0d, value %0d",
                 rsp.status, rsp.out_value);
          failures++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("out_priority", want.pri, rsp.out_priority);
          check_field("out_value", want.value, rsp.out_value);
          check_field("out_position", want.pos, rsp.out_position);
          check_field("entry_count", want.count, rsp.entry_count);
        end
      end
      if (req.valid && req.ready)
        pending_outcomes.push_back(queue_op_outcome(req.operation, req.entry_priority,
                                                    req.entry_value, req.position));
    end
    pending = pending_outcomes.size();
  end

endmodule

/* dv/sorted_priority_queue_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted priority queue: drives request items with random gaps,
// throttles the result channel and gives the verdict from the failure count of the checker.
// Depends on spq_pkg, spq_if, sorted_priority_queue and spq_result_checker.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PW          = $clog2(DEPTH + 1);
  localparam int N_RANDOM    = 1150;
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

  localparam logic [PRI_W-1:0] FILL_PRI [16] = '{
    16'hFFFF, 16'd0, 16'd100, 16'd100, 16'd7, 16'hFFFF, 16'd0, 16'd100,
    16'd3, 16'd50, 16'd50, 16'd1, 16'hFFFE, 16'd100, 16'd2, 16'd9
  };

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   checked;
  bit   req_idle_on;
  bit   rsp_idle_on;
  int   hold_requests;
  int   op_sent [1 << OP_W];

  spq_in_if  #(.DEPTH(DEPTH)) req_ch ();
  spq_out_if #(.DEPTH(DEPTH)) rsp_ch ();

  sorted_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk,
    .rst,
    .req (req_ch),
    .rsp (rsp_ch)
  );

  spq_result_checker #(.DEPTH(DEPTH)) result_check (
    .clk,
    .rst,
    .req      (req_ch),
    .rsp      (rsp_ch),
    .failures,
    .pending,
    .checked
  );

  function automatic int draw_gap(input bit on);
    if (!on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_W'($urandom_range(int'(OP_SEARCH) + 1, int'(OP_TOP_CODE)));
    case (kind)
      PH_FILL:  if (r < 75) return OP_INSERT;
      PH_DRAIN: if (r < 18) return OP_INSERT;
      default:  if (r < 45) return OP_INSERT;
    endcase
    case ($urandom_range(0, 3))
      0:       return OP_HEAD;
      1:       return OP_TAIL;
      2:       return OP_AT;
      default: return OP_SEARCH;
    endcase
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PRI_W'($urandom_range(0, 3));
    if (r < 50) return (r % 2 == 0) ? '0 : '1;
    return PRI_W'($urandom);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return VAL_W'(int'($urandom_range(0, 7)) - 4);
    if (r < 66) return (r % 2 == 0) ? {1'b0, {(VAL_W-1){1'b1}}} : {1'b1, {(VAL_W-1){1'b0}}};
    return $urandom;
  endfunction

  function automatic logic [PW-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return PW'($urandom_range(1, DEPTH));
    if (r < 92) return '0;
    return PW'($urandom_range(DEPTH + 1, (1 << PW) - 1));
  endfunction

  task automatic send_item(input logic [OP_W-1:0]         op,
                           input logic [PRI_W-1:0]        pri,
                           input logic signed [VAL_W-1:0] val,
                           input logic [PW-1:0]           pos);
    int gap;
    gap = draw_gap(req_idle_on);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= op;
    req_ch.entry_priority <= pri;
    req_ch.entry_value    <= val;
    req_ch.position       <= pos;
    op_sent[op]++;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int gap;
    int holds_done;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = draw_gap(rsp_idle_on);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    phase_kind_t     kind;
    logic [OP_W-1:0] op;
    int              useful;
    int              phase;
    int              len;
    int              k;
    int              unused_ops;
    req_ch.valid          <= 1'b0;
    req_ch.operation      <= OP_INSERT;
    req_ch.entry_priority <= '0;
    req_ch.entry_value    <= '0;
    req_ch.position       <= '0;
    rst           = 1'b1;
    req_idle_on   = 1'b1;
    rsp_idle_on   = 1'b1;
    hold_requests = 0;
    foreach (op_sent[k]) op_sent[k] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(OP_HEAD, '0, '0, '0);
    send_item(OP_TAIL, '0, '0, '0);
    send_item(OP_AT, '0, '0, PW'(1));
    send_item(OP_SEARCH, '0, '0, '0);
    for (k = 0; k < DEPTH; k++)
      send_item(OP_INSERT, FILL_PRI[k % 16],
                (k == 0) ? {1'b0, {(VAL_W-1){1'b1}}} :
                (k == 1) ? {1'b1, {(VAL_W-1){1'b0}}} : VAL_W'(k * 3 - 20), '0);
    send_item(OP_INSERT, 16'd1234, 32'sd99, '0);
    send_item(OP_SEARCH, '0, {1'b1, {(VAL_W-1){1'b0}}}, '0);
    send_item(OP_SEARCH, '0, 32'sd12345, '0);
    send_item(OP_AT, '0, '0, '0);
    send_item(OP_AT, '0, '0, '1);
    send_item(OP_AT, '0, '0, PW'(DEPTH));
    send_item(OP_TAIL, '0, '0, '0);
    send_item(OP_HEAD, '0, '0, '0);
    send_item(OP_AT, '0, '0, PW'(5));
    send_item(OP_TOP_CODE, '1, '1, '1);

    useful = 0;
    phase  = 0;
    while (useful < N_RANDOM) begin
      kind        = phase_kind_t'($urandom_range(0, 2));
      req_idle_on = $urandom_range(0, 2) != 0;
      rsp_idle_on = $urandom_range(0, 2) != 0;
      if (phase == 2) begin
        kind        = PH_FILL;
        req_idle_on = 1'b0;
        hold_requests++;
      end
      if (phase == 4 || (phase > 0 && $urandom_range(0, 5) == 0)) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
      end
      len = $urandom_range(20, 60);
      repeat (len) begin
        op = pick_op(kind);
        send_item(op, pick_priority(), pick_value(), pick_position());
        if (op <= OP_SEARCH) useful++;
      end
      phase++;
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DEPTH + 8) @(posedge clk);

    unused_ops = 0;
    for (k = int'(OP_SEARCH) + 1; k < (1 << OP_W); k++) unused_ops += op_sent[k];
    $display("Ran %0d phases: %0d inserts, %0d head, %0d tail, %0d positional removes",
             phase, op_sent[OP_INSERT], op_sent[OP_HEAD], op_sent[OP_TAIL], op_sent[OP_AT]);
    $display("plus %0d searches and %0d unused codes; %0d results checked", op_sent[OP_SEARCH],
             unused_ops, checked);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
